### hw/rtl/ppr_pkg.sv
// Shared widths and controller/datapath interface types for the port priority remapper.
package ppr_pkg;

  localparam int unsigned PortW  = 3;
  localparam int unsigned PrioW  = 3;
  localparam int unsigned PowerW = 16;
  localparam int unsigned TotalW = 17;
  localparam int unsigned UpW    = 6;

  typedef struct packed {
    logic load;
    logic emit;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic req_ok;
    logic slot_free;
  } status_t;

endpackage

### hw/rtl/ppr_ctrl.sv
// Controller FSM: accepts a request, then one rank beat per cycle while slot_free.
module ppr_ctrl #(
  parameter int unsigned PORTS = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ppr_pkg::status_t status_i,
  output ppr_pkg::cmd_t   cmd_o
);

  localparam int unsigned CntW = $clog2(PORTS);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRank = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign in_ready_o  = (state_q == StIdle);
  assign cmd_o.load  = (state_q == StIdle) && in_valid_i && status_i.req_ok;
  assign cmd_o.emit  = (state_q == StRank) && status_i.slot_free;
  assign cmd_o.last  = (cnt_q == CntW'(PORTS - 1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        if (cmd_o.load) begin
          state_d = StRank;
          cnt_d   = '0;
        end
      end
      StRank: begin
        if (cmd_o.emit) begin
          cnt_d = cnt_q + CntW'(1);
          if (cmd_o.last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### hw/rtl/ppr_datapath.sv
// Datapath: per-port request store, cleanup, rank selection and output beat register.
module ppr_datapath #(
  parameter int unsigned PORTS        = 6,
  parameter int unsigned MAX_PRIORITY = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ppr_pkg::cmd_t                 cmd_i,
  output ppr_pkg::status_t              status_o,
  input  logic [ppr_pkg::PortW-1:0]     port_i,
  input  logic [ppr_pkg::PrioW-1:0]     priority_req_i,
  input  logic [ppr_pkg::PowerW-1:0]    power_12v_i,
  input  logic [ppr_pkg::PowerW-1:0]    power_48v_i,
  input  logic [ppr_pkg::UpW-1:0]       ports_up_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ppr_pkg::PortW-1:0]     ranked_port_o,
  output logic [ppr_pkg::PrioW-1:0]     remapped_priority_o,
  output logic [ppr_pkg::PrioW-1:0]     requested_level_o,
  output logic                          priority_changed_o,
  output logic [ppr_pkg::TotalW-1:0]    total_power_o,
  output logic                          last_o
);

  localparam int unsigned IdxW = $clog2(PORTS);

  logic [ppr_pkg::PrioW-1:0]  req_q  [PORTS];
  logic [ppr_pkg::PowerW-1:0] p12_q  [PORTS];
  logic [ppr_pkg::PowerW-1:0] p48_q  [PORTS];
  logic [ppr_pkg::PrioW-1:0]  act_q  [PORTS];
  logic [PORTS-1:0]           done_q;
  logic [ppr_pkg::PrioW-1:0]  next_q;

  logic                       out_valid_q;
  logic [ppr_pkg::PortW-1:0]  ranked_q;
  logic [ppr_pkg::PrioW-1:0]  remap_q;
  logic [ppr_pkg::PrioW-1:0]  level_q;
  logic                       changed_q;
  logic [ppr_pkg::TotalW-1:0] total_q;
  logic                       last_q;

  logic [IdxW-1:0]            best;
  logic                       found;
  logic [ppr_pkg::PrioW-1:0]  remap;

  assign status_o.req_ok    = (int'(port_i) < PORTS) && (int'(priority_req_i) <= MAX_PRIORITY);
  assign status_o.slot_free = !out_valid_q || out_ready_i;

  // highest request first, higher port index wins ties
  always_comb begin
    best  = '0;
    found = 1'b0;
    for (int j = 0; j < PORTS; j++) begin
      if (!done_q[j] && (!found || req_q[j] >= req_q[best])) begin
        best  = IdxW'(j);
        found = 1'b1;
      end
    end
  end

  assign remap = (req_q[best] != '0) ? next_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < PORTS; j++) begin
        req_q[j] <= '0;
        p12_q[j] <= '0;
        p48_q[j] <= '0;
        act_q[j] <= '0;
      end
      done_q <= '0;
      next_q <= ppr_pkg::PrioW'(MAX_PRIORITY);
    end else if (cmd_i.load) begin
      for (int j = 0; j < PORTS; j++) begin
        if (port_i[IdxW-1:0] == IdxW'(j)) begin
          if (priority_req_i != '0 && !ports_up_i[j]) begin
            req_q[j] <= '0;
            p12_q[j] <= '0;
            p48_q[j] <= '0;
          end else begin
            req_q[j] <= priority_req_i;
            p12_q[j] <= power_12v_i;
            p48_q[j] <= power_48v_i;
          end
        end else if (req_q[j] != '0 && !ports_up_i[j]) begin
          req_q[j] <= '0;
          p12_q[j] <= '0;
          p48_q[j] <= '0;
        end
      end
      done_q <= '0;
      next_q <= ppr_pkg::PrioW'(MAX_PRIORITY);
    end else if (cmd_i.emit) begin
      done_q[best] <= 1'b1;
      act_q[best]  <= remap;
      if (req_q[best] != '0) begin
        next_q <= next_q - ppr_pkg::PrioW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      ranked_q  <= ppr_pkg::PortW'(best);
      remap_q   <= remap;
      level_q   <= req_q[best];
      changed_q <= (act_q[best] != remap);
      total_q   <= ppr_pkg::TotalW'(p12_q[best]) + ppr_pkg::TotalW'(p48_q[best]);
      last_q    <= cmd_i.last;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign ranked_port_o       = ranked_q;
  assign remapped_priority_o = remap_q;
  assign requested_level_o   = level_q;
  assign priority_changed_o  = changed_q;
  assign total_power_o       = total_q;
  assign last_o              = last_q;

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("beat loaded over an untaken beat");

  a_emit_has_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> found)
    else $error("rank beat with no port left");

  a_load_clears_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (done_q == '0))
    else $error("rank mask not cleared on load");

  a_last_all_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.last) |=> (&done_q))
    else $error("last beat with ports left unranked");

endmodule

### hw/rtl/port_priority_remapper.sv
// Top level of the port priority remapper: controller plus datapath.
// An accepted request with a valid port and priority is stored, with any port
// whose link is down losing a nonzero request and its power; the block then
// gives PORTS result beats, one per cycle while out_ready_i is high, highest
// remapped priority first, with last_o on the final beat. The rank selector
// picks one port per beat; a rejected request is taken and gives no beat.
// in_ready_o is high whenever no ranking run is in progress.
module port_priority_remapper #(
  parameter int unsigned PORTS        = 6,
  parameter int unsigned MAX_PRIORITY = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ppr_pkg::PortW-1:0]     port_i,
  input  logic [ppr_pkg::PrioW-1:0]     priority_req_i,
  input  logic [ppr_pkg::PowerW-1:0]    power_12v_i,
  input  logic [ppr_pkg::PowerW-1:0]    power_48v_i,
  input  logic [ppr_pkg::UpW-1:0]       ports_up_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ppr_pkg::PortW-1:0]     ranked_port_o,
  output logic [ppr_pkg::PrioW-1:0]     remapped_priority_o,
  output logic [ppr_pkg::PrioW-1:0]     requested_level_o,
  output logic                          priority_changed_o,
  output logic [ppr_pkg::TotalW-1:0]    total_power_o,
  output logic                          last_o
);

  ppr_pkg::cmd_t    cmd;
  ppr_pkg::status_t status;

  ppr_ctrl #(
    .PORTS (PORTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ppr_datapath #(
    .PORTS        (PORTS),
    .MAX_PRIORITY (MAX_PRIORITY)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .port_i              (port_i),
    .priority_req_i      (priority_req_i),
    .power_12v_i         (power_12v_i),
    .power_48v_i         (power_48v_i),
    .ports_up_i          (ports_up_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .ranked_port_o       (ranked_port_o),
    .remapped_priority_o (remapped_priority_o),
    .requested_level_o   (requested_level_o),
    .priority_changed_o  (priority_changed_o),
    .total_power_o       (total_power_o),
    .last_o              (last_o)
  );

endmodule
